// ===== src/lrh_pkg.sv =====
// Shared types, constants and bin arithmetic of the LSB run-length histogram unit.
package lrh_pkg;

	localparam int MAX_RUN     = 8;
	localparam int COUNT_WIDTH = 16;
	localparam int NUM_BINS    = 2 * MAX_RUN;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int LEN_W       = $clog2(MAX_RUN + 1);
	localparam int COEF_W      = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef logic [BIN_W-1:0] bin_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic                     end_of_image;
	} coef_beat_t;

	typedef struct packed {
		bin_t                   bin_index;
		logic [COUNT_WIDTH-1:0] bin_count;
		logic                   last_bin;
	} bin_beat_t;

	typedef struct packed {
		logic inc_a;
		bin_t idx_a;
		logic inc_b;
		bin_t idx_b;
		logic last;
	} event_t;

	function automatic bin_t bin_of(input len_t len, input logic bit_v);
		len_t lm1;
		lm1 = len - len_t'(1);
		return bin_t'(lm1) + (bit_v ? bin_t'(MAX_RUN) : bin_t'(0));
	endfunction

endpackage

// ===== src/lrh_front.sv =====
// Front part: accepts coefficients, tracks the open run and posts bin events.
module lrh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              coef_valid,
	output logic              coef_stall,
	input  lrh_pkg::coef_beat_t coef_beat,
	output logic              push,
	output lrh_pkg::event_t   push_event,
	input  logic              full
);
	import lrh_pkg::*;

	logic run_bit_q;
	logic run_open_q;
	len_t run_len_q;

	logic   accept;
	logic   nz;
	logic   bit_in;
	logic   extend;
	logic   nxt_bit;
	logic   nxt_open;
	len_t   nxt_len;
	event_t ev;

	assign coef_stall = full;
	assign accept     = coef_valid && !full;
	assign nz         = coef_beat.coefficient != '0;
	assign bit_in     = coef_beat.coefficient[0];
	assign extend     = run_open_q && (bit_in == run_bit_q) && (run_len_q < len_t'(MAX_RUN));

	always_comb begin
		nxt_bit  = run_bit_q;
		nxt_open = run_open_q;
		nxt_len  = run_len_q;
		ev       = '0;
		if (nz && extend) begin
			nxt_len = run_len_q + len_t'(1);
		end else if (nz) begin
			ev.inc_a = run_open_q;
			ev.idx_a = bin_of(run_len_q, run_bit_q);
			nxt_bit  = bit_in;
			nxt_len  = len_t'(1);
			nxt_open = 1'b1;
		end
		if (coef_beat.end_of_image) begin
			ev.inc_b = nxt_open;
			ev.idx_b = bin_of(nxt_len, nxt_bit);
			ev.last  = 1'b1;
		end
	end

	assign push       = accept && (ev.inc_a || ev.inc_b || ev.last);
	assign push_event = ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_bit_q  <= 1'b0;
			run_open_q <= 1'b0;
			run_len_q  <= '0;
		end else if (accept) begin
			if (coef_beat.end_of_image) begin
				run_bit_q  <= 1'b0;
				run_open_q <= 1'b0;
				run_len_q  <= '0;
			end else begin
				run_bit_q  <= nxt_bit;
				run_open_q <= nxt_open;
				run_len_q  <= nxt_len;
			end
		end
	end

endmodule

// ===== src/lrh_queue.sv =====
// Short event queue between the front and back parts.
module lrh_queue #(
	parameter int DEPTH = lrh_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lrh_pkg::event_t push_event,
	output logic            full,
	input  logic            pop,
	output lrh_pkg::event_t pop_event,
	output logic            empty
);
	import lrh_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	event_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_event = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/lrh_back.sv =====
// Back part: applies bin events to the histogram and streams the readout.
module lrh_back (
	input  logic               clk,
	input  logic               arst_n,
	output logic               pop,
	input  lrh_pkg::event_t    pop_event,
	input  logic               empty,
	output logic               bin_valid,
	input  logic               bin_stall,
	output lrh_pkg::bin_beat_t bin_beat
);
	import lrh_pkg::*;

	logic [COUNT_WIDTH-1:0] hist_q [NUM_BINS];
	logic                   reading_q;
	bin_t                   rd_idx_q;
	logic                   out_valid_q;
	bin_beat_t              out_q;
	logic                   load;
	logic                   final_bin;

	assign pop       = !empty && !reading_q;
	assign load      = reading_q && (!out_valid_q || !bin_stall);
	assign final_bin = rd_idx_q == bin_t'(NUM_BINS - 1);
	assign bin_valid = out_valid_q;
	assign bin_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BINS; k++) begin
				hist_q[k] <= '0;
			end
		end else if (load && final_bin) begin
			for (int k = 0; k < NUM_BINS; k++) begin
				hist_q[k] <= '0;
			end
		end else if (pop) begin
			for (int k = 0; k < NUM_BINS; k++) begin
				if (((pop_event.inc_a && pop_event.idx_a == bin_t'(k)) ||
				     (pop_event.inc_b && pop_event.idx_b == bin_t'(k))) &&
				    hist_q[k] != COUNT_MAX) begin
					hist_q[k] <= hist_q[k] + COUNT_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q   <= 1'b0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && pop_event.last) begin
				reading_q <= 1'b1;
				rd_idx_q  <= '0;
			end else if (load) begin
				rd_idx_q <= rd_idx_q + bin_t'(1);
				if (final_bin) begin
					reading_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!bin_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.bin_index <= rd_idx_q;
			out_q.bin_count <= hist_q[rd_idx_q];
			out_q.last_bin  <= final_bin;
		end
	end

endmodule

// ===== src/lsb_run_length_histogram_unit.sv =====
// Top level of the LSB run-length histogram unit.
// Takes one coefficient per cycle while coef_stall is low. Nonzero
// coefficients build runs of equal LSB; each ended run bumps one of 16
// saturating bins. The beat marked end_of_image flushes the open run and
// triggers a readout of all 16 bins, one beat per cycle while bin_stall is
// low, with last_bin on bin 15, after which the histogram clears. During
// readout the front keeps accepting coefficients until the QUEUE_DEPTH-entry
// event queue fills.
module lsb_run_length_histogram_unit #(
	parameter int QUEUE_DEPTH = lrh_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                coef_valid,
	output logic                coef_stall,
	input  lrh_pkg::coef_beat_t coef_beat,
	output logic                bin_valid,
	input  logic                bin_stall,
	output lrh_pkg::bin_beat_t  bin_beat
);
	import lrh_pkg::*;

	logic   push;
	logic   full;
	logic   pop;
	logic   empty;
	event_t push_event;
	event_t pop_event;

	lrh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_valid (coef_valid),
		.coef_stall (coef_stall),
		.coef_beat  (coef_beat),
		.push       (push),
		.push_event (push_event),
		.full       (full)
	);

	lrh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_event (push_event),
		.full       (full),
		.pop        (pop),
		.pop_event  (pop_event),
		.empty      (empty)
	);

	lrh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_event (pop_event),
		.empty     (empty),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_beat  (bin_beat)
	);

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the LSB run-length histogram unit.
`timescale 1ns / 100ps

module testbench;
	import lrh_pkg::*;

	typedef struct packed {
		logic [COEF_W-1:0]      coefficient;
		logic                   end_of_image;
		logic                   typed;
		bin_t                   typed_bin;
		logic [COUNT_WIDTH-1:0] typed_count;
	} coef_row_t;

	localparam int NUM_ROWS = 22;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       coef_valid = 1'b0;
	logic       coef_stall;
	coef_beat_t coef_beat = '0;
	logic       bin_valid;
	logic       bin_stall = 1'b0;
	bin_beat_t  bin_beat;

	int coef_idle_pct = 0;
	int bin_stall_pct = 0;
	int mismatch_count = 0;

	logic                   run_lsb = 1'b0;
	logic                   run_active = 1'b0;
	int                     run_len = 0;
	logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];
	bin_beat_t              bin_expect [$];

	coef_row_t directed_rows [NUM_ROWS] = '{
		'{16'h0000, 1'b1, 1'b1, 4'd0, 16'd0},
		'{16'hFFFF, 1'b1, 1'b1, 4'd8, 16'd1},
		'{16'h7FFF, 1'b1, 1'b1, 4'd8, 16'd1},
		'{16'h8000, 1'b1, 1'b1, 4'd0, 16'd1},
		'{16'h0002, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0004, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0000, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0006, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0001, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0003, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0000, 1'b1, 1'b0, 4'd0, 16'd0},
		'{16'h0001, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0003, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0005, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0007, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0009, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h000B, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h000D, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h000F, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'h0011, 1'b1, 1'b0, 4'd0, 16'd0},
		'{16'h5555, 1'b0, 1'b0, 4'd0, 16'd0},
		'{16'hAAAA, 1'b1, 1'b0, 4'd0, 16'd0}
	};

	lsb_run_length_histogram_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_valid(coef_valid),
		.coef_stall(coef_stall),
		.coef_beat (coef_beat),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_beat  (bin_beat)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		foreach (bin_tally[k])
			bin_tally[k] = '0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic tally_run();
		bin_t idx;
		idx = bin_t'(run_len - 1 + MAX_RUN * int'(run_lsb));
		if (bin_tally[idx] != COUNT_MAX)
			bin_tally[idx]++;
	endtask

	task automatic absorb_coef(input coef_beat_t b, input bit emit);
		logic      lsb_now;
		bin_beat_t e;
		if (b.coefficient != 0) begin
			lsb_now = b.coefficient[0];
			if (run_active && lsb_now == run_lsb && run_len < MAX_RUN) begin
				run_len++;
			end else begin
				if (run_active)
					tally_run();
				run_lsb = lsb_now;
				run_len = 1;
				run_active = 1'b1;
			end
		end
		if (b.end_of_image) begin
			if (run_active)
				tally_run();
			for (int k = 0; k < NUM_BINS; k++) begin
				e.bin_index = bin_t'(k);
				e.bin_count = bin_tally[k];
				e.last_bin = (k == NUM_BINS - 1);
				if (emit)
					bin_expect = {bin_expect, e};
				bin_tally[k] = '0;
			end
			run_active = 1'b0;
			run_lsb = 1'b0;
			run_len = 0;
		end
	endtask

	task automatic check_bin_beat(input bin_beat_t got);
		bin_beat_t want;
		if (bin_expect.size() == 0) begin
			report_mismatch($sformatf("unexpected beat, bin %0d count %0d",
				got.bin_index, got.bin_count));
		end else begin
			want = bin_expect.pop_front();
			if (got.bin_index != want.bin_index)
				report_mismatch($sformatf("bin_index got %0d want %0d",
					got.bin_index, want.bin_index));
			if (got.bin_count != want.bin_count)
				report_mismatch($sformatf("bin %0d bin_count got %0d want %0d",
					want.bin_index, got.bin_count, want.bin_count));
			if (got.last_bin != want.last_bin)
				report_mismatch($sformatf("bin %0d last_bin got %0b want %0b",
					want.bin_index, got.last_bin, want.last_bin));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && bin_valid && !bin_stall)
			check_bin_beat(bin_beat);
		bin_stall <= ($urandom_range(99) < bin_stall_pct);
	end

	task automatic send_coef(input coef_beat_t b);
		while ($urandom_range(99) < coef_idle_pct) begin
			coef_valid <= 1'b0;
			@(posedge clk);
		end
		coef_valid <= 1'b1;
		coef_beat <= b;
		@(posedge clk);
		while (coef_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		coef_valid <= 1'b0;
		do
			@(posedge clk);
		while (bin_expect.size() != 0);
	endtask

	task automatic run_images(input int n_items);
		int          sent;
		int          len;
		logic        lsb;
		logic [15:0] c;
		coef_beat_t  b;
		sent = 0;
		lsb = 1'b0;
		while (sent < n_items) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(9))
					0, 1: c = '0;
					2: c = 16'($urandom);
					3: c = $urandom_range(1) ? 16'h7FFF : 16'h8000;
					default: begin
						if ($urandom_range(3) == 0)
							lsb = ~lsb;
						c = {15'($urandom), lsb};
					end
				endcase
				b.coefficient = c;
				b.end_of_image = (i == len - 1);
				send_coef(b);
				absorb_coef(b, 1'b1);
				sent++;
			end
		end
	endtask

	initial begin
		coef_beat_t b;
		coef_row_t  row;
		bin_beat_t  e;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		coef_idle_pct = 28;
		bin_stall_pct = 81;
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			b.coefficient = row.coefficient;
			b.end_of_image = row.end_of_image;
			send_coef(b);
			absorb_coef(b, !row.typed);
			if (row.typed) begin
				for (int k = 0; k < NUM_BINS; k++) begin
					e.bin_index = bin_t'(k);
					e.bin_count = (bin_t'(k) == row.typed_bin) ? row.typed_count : '0;
					e.last_bin = (k == NUM_BINS - 1);
					bin_expect = {bin_expect, e};
				end
			end
		end
		run_images(120);
		wait_drained();

		coef_idle_pct = 81;
		bin_stall_pct = 28;
		run_images(120);
		wait_drained();

		coef_idle_pct = 0;
		bin_stall_pct = 0;
		run_images(120);
		wait_drained();
		repeat (40) @(posedge clk);

		if (mismatch_count == 0 && bin_expect.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

endmodule
